### src/bcr_pkg.sv
// shared types and constants of the bus character receiver
`default_nettype none

package bcr_pkg;

  localparam int unsigned WAIT_W = 16;
  localparam int unsigned READS_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FIRST_WAIT = 3'd0;
  localparam cfg_idx_t CFG_SECOND_WAIT = 3'd1;
  localparam cfg_idx_t CFG_BIT_WAIT = 3'd2;
  localparam cfg_idx_t CFG_END_TIMEOUT = 3'd3;
  localparam cfg_idx_t CFG_SAMPLE_READS = 3'd4;

  localparam logic [WAIT_W-1:0] FIRST_WAIT_RST = 16'd400;
  localparam logic [WAIT_W-1:0] SECOND_WAIT_RST = 16'd379;
  localparam logic [WAIT_W-1:0] BIT_WAIT_RST = 16'd373;
  localparam logic [WAIT_W-1:0] END_TIMEOUT_RST = 16'd1481;
  localparam logic [READS_W-1:0] SAMPLE_READS_RST = 4'd6;

  localparam logic [5:0] POS_MAX = 6'd63;
  localparam logic [3:0] PARITY_BIT = 4'd8;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_PARITY = 2'd1,
    KIND_END    = 2'd2
  } result_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_WAIT   = 4'b0010,
    PH_AFTER  = 4'b0100,
    PH_SAMPLE = 4'b1000
  } phase_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   data_byte;
    logic [5:0]   byte_index;
    logic [7:0]   checksum;
  } result_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/bcr_if.sv
// valid/ready channel interfaces for line samples and results
`default_nettype none

interface bcr_in_if;
  logic valid;
  logic ready;
  logic line_level;

  modport source (output valid, output line_level, input ready);
  modport sink (input valid, input line_level, output ready);
endinterface

interface bcr_out_if;
  logic                 valid;
  logic                 ready;
  bcr_pkg::result_kind_t result_kind;
  logic [7:0]           data_byte;
  logic [5:0]           byte_index;
  logic [7:0]           checksum;

  modport source (output valid, output result_kind, output data_byte,
                  output byte_index, output checksum, input ready);
  modport sink (input valid, input result_kind, input data_byte,
                input byte_index, input checksum, output ready);
endinterface

`default_nettype wire

### src/bus_character_receiver.sv
// bus character receiver: line samples in, bytes, parity errors and telegram ends out
//
//  channel  dir  payload                                        transfer
//  in_if    in   line_level                                     valid & ready
//  out_if   out  result_kind, data_byte, byte_index, checksum   valid & ready
//  cfg_*    in   cfg_index, cfg_wdata                           cfg_we
//
//  one sample per cycle unless stalled; a result shows the cycle after its transfer
//  a single output register; in_if.ready is low only while it holds an untaken result
//  synchronous active-low reset restores register defaults and the idle line state
`default_nettype none

module bus_character_receiver (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  bcr_in_if.sink                                       in_if,
  bcr_out_if.source                                    out_if,
  input  wire logic                                    cfg_we,
  input  wire logic [bcr_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [bcr_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

  logic [15:0] first_wait_r, second_wait_r, bit_wait_r, end_timeout_r;
  logic [3:0]  sample_reads_r;

  bcr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] tick_count_r, tick_count_nxt;
  logic [3:0]  bit_number_r, bit_number_nxt;
  logic [2:0]  read_count_r, read_count_nxt;
  logic        sample_and_r, sample_and_nxt;
  logic [7:0]  shift_value_r, shift_value_nxt;
  logic        parity_acc_r, parity_acc_nxt;
  logic [5:0]  byte_position_r, byte_position_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic        last_level_r;

  logic            out_valid_r;
  bcr_pkg::result_t result_r, result_nxt;
  logic            emit;

  logic        fire, level, fall, finish, bit_val;
  logic [15:0] tc_inc, target;
  logic [2:0]  reads_m1;
  logic [7:0]  xor_base, xor_new;

  assign in_if.ready = ~out_valid_r | out_if.ready;
  assign fire        = in_if.valid & in_if.ready;
  assign level       = in_if.line_level;
  assign fall        = last_level_r & ~level;
  assign tc_inc      = (tick_count_r == 16'hFFFF) ? tick_count_r : tick_count_r + 16'd1;

  always_comb begin
    if (sample_reads_r == 4'd0) begin
      reads_m1 = 3'd0;
    end else if (sample_reads_r > 4'd8) begin
      reads_m1 = 3'd7;
    end else begin
      reads_m1 = 3'(sample_reads_r - 4'd1);
    end
  end

  always_comb begin
    if (bit_number_r == 4'd0) begin
      target = first_wait_r;
    end else if (bit_number_r == 4'd1) begin
      target = second_wait_r;
    end else begin
      target = bit_wait_r;
    end
  end

  assign xor_base = (byte_position_r == 6'd0) ? 8'd0 : running_xor_r;
  assign xor_new  = xor_base ^ shift_value_r;

  always_comb begin
    phase_nxt         = phase_r;
    tick_count_nxt    = tick_count_r;
    bit_number_nxt    = bit_number_r;
    read_count_nxt    = read_count_r;
    sample_and_nxt    = sample_and_r;
    shift_value_nxt   = shift_value_r;
    parity_acc_nxt    = parity_acc_r;
    byte_position_nxt = byte_position_r;
    running_xor_nxt   = running_xor_r;
    finish            = 1'b0;
    bit_val           = 1'b0;
    emit              = 1'b0;
    result_nxt        = result_r;

    unique case (phase_r)
      bcr_pkg::PH_IDLE: begin
        if (fall) begin
          phase_nxt       = bcr_pkg::PH_WAIT;
          tick_count_nxt  = 16'd0;
          bit_number_nxt  = 4'd0;
          read_count_nxt  = 3'd0;
          sample_and_nxt  = 1'b1;
          shift_value_nxt = 8'd0;
          parity_acc_nxt  = 1'b0;
        end
      end
      bcr_pkg::PH_AFTER: begin
        if (fall) begin
          phase_nxt       = bcr_pkg::PH_WAIT;
          tick_count_nxt  = 16'd0;
          bit_number_nxt  = 4'd0;
          read_count_nxt  = 3'd0;
          sample_and_nxt  = 1'b1;
          shift_value_nxt = 8'd0;
          parity_acc_nxt  = 1'b0;
        end else if (tc_inc >= end_timeout_r) begin
          emit                   = 1'b1;
          result_nxt.result_kind = bcr_pkg::KIND_END;
          result_nxt.data_byte   = 8'd0;
          result_nxt.byte_index  = byte_position_r;
          result_nxt.checksum    = running_xor_r;
          byte_position_nxt      = 6'd0;
          running_xor_nxt        = 8'd0;
          tick_count_nxt         = 16'd0;
          phase_nxt              = bcr_pkg::PH_IDLE;
        end else begin
          tick_count_nxt = tc_inc;
        end
      end
      bcr_pkg::PH_WAIT: begin
        if (tc_inc >= target) begin
          tick_count_nxt = 16'd0;
          sample_and_nxt = level;
          read_count_nxt = reads_m1;
          if (reads_m1 == 3'd0) begin
            finish  = 1'b1;
            bit_val = level;
          end else begin
            phase_nxt = bcr_pkg::PH_SAMPLE;
          end
        end else begin
          tick_count_nxt = tc_inc;
        end
      end
      bcr_pkg::PH_SAMPLE: begin
        tick_count_nxt = tc_inc;
        sample_and_nxt = sample_and_r & level;
        read_count_nxt = read_count_r - 3'd1;
        if (read_count_r == 3'd1) begin
          finish  = 1'b1;
          bit_val = sample_and_r & level;
        end
      end
      default: begin
        phase_nxt = bcr_pkg::PH_IDLE;
      end
    endcase

    if (finish) begin
      if (bit_number_r < bcr_pkg::PARITY_BIT) begin
        shift_value_nxt = {shift_value_r[6:0], bit_val};
        parity_acc_nxt  = parity_acc_r ^ bit_val;
        bit_number_nxt  = bit_number_r + 4'd1;
        phase_nxt       = bcr_pkg::PH_WAIT;
      end else begin
        phase_nxt      = bcr_pkg::PH_AFTER;
        tick_count_nxt = 16'd0;
        emit           = 1'b1;
        if (bit_val == parity_acc_r) begin
          running_xor_nxt        = xor_new;
          result_nxt.result_kind = bcr_pkg::KIND_BYTE;
          result_nxt.data_byte   = bcr_pkg::reverse8(shift_value_r);
          result_nxt.byte_index  = byte_position_r;
          result_nxt.checksum    = xor_new;
          if (byte_position_r < bcr_pkg::POS_MAX) begin
            byte_position_nxt = byte_position_r + 6'd1;
          end
        end else begin
          result_nxt.result_kind = bcr_pkg::KIND_PARITY;
          result_nxt.data_byte   = 8'hFF;
          result_nxt.byte_index  = byte_position_r;
          result_nxt.checksum    = running_xor_r;
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_wait_r   <= bcr_pkg::FIRST_WAIT_RST;
      second_wait_r  <= bcr_pkg::SECOND_WAIT_RST;
      bit_wait_r     <= bcr_pkg::BIT_WAIT_RST;
      end_timeout_r  <= bcr_pkg::END_TIMEOUT_RST;
      sample_reads_r <= bcr_pkg::SAMPLE_READS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcr_pkg::CFG_FIRST_WAIT:   first_wait_r   <= cfg_wdata;
        bcr_pkg::CFG_SECOND_WAIT:  second_wait_r  <= cfg_wdata;
        bcr_pkg::CFG_BIT_WAIT:     bit_wait_r     <= cfg_wdata;
        bcr_pkg::CFG_END_TIMEOUT:  end_timeout_r  <= cfg_wdata;
        bcr_pkg::CFG_SAMPLE_READS: sample_reads_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= bcr_pkg::PH_IDLE;
      tick_count_r    <= 16'd0;
      bit_number_r    <= 4'd0;
      read_count_r    <= 3'd0;
      sample_and_r    <= 1'b1;
      shift_value_r   <= 8'd0;
      parity_acc_r    <= 1'b0;
      byte_position_r <= 6'd0;
      running_xor_r   <= 8'd0;
      last_level_r    <= 1'b1;
    end else if (fire) begin
      phase_r         <= phase_nxt;
      tick_count_r    <= tick_count_nxt;
      bit_number_r    <= bit_number_nxt;
      read_count_r    <= read_count_nxt;
      sample_and_r    <= sample_and_nxt;
      shift_value_r   <= shift_value_nxt;
      parity_acc_r    <= parity_acc_nxt;
      byte_position_r <= byte_position_nxt;
      running_xor_r   <= running_xor_nxt;
      last_level_r    <= level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.result_kind = result_r.result_kind;
  assign out_if.data_byte   = result_r.data_byte;
  assign out_if.byte_index  = result_r.byte_index;
  assign out_if.checksum    = result_r.checksum;

endmodule

`default_nettype wire

### tb/tb.sv
// testbench for the bus character receiver: line samples in, checked results out
`timescale 1ns / 1ps

module tb;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_SAMPLES = 100;
  localparam int unsigned RANDOM_RESULTS = 6;
  localparam bcr_pkg::cfg_idx_t CFG_NO_REG = 3'd7;

  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_SLOW,
    DRAIN_BEAT
  } drain_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  bcr_pkg::cfg_idx_t cfg_index;
  logic [bcr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bcr_in_if in_ch ();
  bcr_out_if out_ch ();

  bus_character_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies
  logic [15:0] rx_first, rx_second, rx_bitw, rx_end;
  logic [3:0] rx_reads;

  // receiver state copy
  bcr_pkg::phase_t ph;
  int unsigned tick_cnt;
  int unsigned bit_no;
  int unsigned reads_left;
  logic bit_and;
  logic [7:0] shift_reg;
  logic parity_sum;
  logic [5:0] byte_pos;
  logic [7:0] xor_sum;
  logic prev_level;

  bcr_pkg::result_t pending_results[$];
  bcr_pkg::result_t oldest;
  int unsigned error_count;
  int unsigned results_seen;
  int unsigned samples_sent;
  int unsigned burst_left;
  int unsigned gap_max;
  bit hold_req;
  drain_mode_t drain_mode;
  int unsigned mode_left;
  int unsigned beat;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned reads_eff();
    return (rx_reads == 0) ? 1 : (rx_reads > 8) ? 8 : rx_reads;
  endfunction

  function automatic int unsigned span(int unsigned w);
    return (w > reads_eff()) ? w : reads_eff();
  endfunction

  function automatic int unsigned sat_tick(int unsigned v);
    return (v >= 16'hFFFF) ? 16'hFFFF : v + 1;
  endfunction

  function automatic void expect_result(bcr_pkg::result_kind_t kind, logic [7:0] data);
    bcr_pkg::result_t r;
    r.result_kind = kind;
    r.data_byte = data;
    r.byte_index = byte_pos;
    r.checksum = xor_sum;
    pending_results.push_back(r);
  endfunction

  function automatic void begin_char();
    ph = bcr_pkg::PH_WAIT;
    tick_cnt = 0;
    bit_no = 0;
    reads_left = 0;
    bit_and = 1'b1;
    shift_reg = 8'h00;
    parity_sum = 1'b0;
  endfunction

  function automatic void close_bit();
    logic [7:0] rev;
    if (bit_no < 8) begin
      shift_reg = {shift_reg[6:0], bit_and};
      parity_sum ^= bit_and;
      bit_no++;
      ph = bcr_pkg::PH_WAIT;
    end else begin
      ph = bcr_pkg::PH_AFTER;
      tick_cnt = 0;
      if (bit_and == parity_sum) begin
        if (byte_pos == 0) xor_sum = 8'h00;
        xor_sum ^= shift_reg;
        for (int i = 0; i < 8; i++) rev[i] = shift_reg[7-i];
        expect_result(bcr_pkg::KIND_BYTE, rev);
        if (byte_pos < bcr_pkg::POS_MAX) byte_pos++;
      end else begin
        expect_result(bcr_pkg::KIND_PARITY, 8'hFF);
      end
    end
  endfunction

  function automatic void track_line_sample(logic lvl);
    logic fall;
    int unsigned target;
    int unsigned tc;
    fall = prev_level && !lvl;
    prev_level = lvl;
    case (ph)
      bcr_pkg::PH_IDLE: begin
        if (fall) begin_char();
      end
      bcr_pkg::PH_AFTER: begin
        if (fall) begin
          begin_char();
        end else begin
          tc = sat_tick(tick_cnt);
          if (tc >= rx_end) begin
            expect_result(bcr_pkg::KIND_END, 8'h00);
            byte_pos = 6'd0;
            xor_sum = 8'h00;
            tick_cnt = 0;
            ph = bcr_pkg::PH_IDLE;
          end else begin
            tick_cnt = tc;
          end
        end
      end
      bcr_pkg::PH_WAIT: begin
        target = (bit_no == 0) ? rx_first : (bit_no == 1) ? rx_second : rx_bitw;
        tc = sat_tick(tick_cnt);
        if (tc >= target) begin
          tick_cnt = 0;
          bit_and = lvl;
          reads_left = reads_eff() - 1;
          if (reads_left == 0) close_bit();
          else ph = bcr_pkg::PH_SAMPLE;
        end else begin
          tick_cnt = tc;
        end
      end
      default: begin
        tick_cnt = sat_tick(tick_cnt);
        bit_and &= lvl;
        reads_left--;
        if (reads_left == 0) close_bit();
      end
    endcase
  endfunction

  function automatic void update_reg(bcr_pkg::cfg_idx_t idx,
                                     logic [bcr_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bcr_pkg::CFG_FIRST_WAIT: rx_first = data;
      bcr_pkg::CFG_SECOND_WAIT: rx_second = data;
      bcr_pkg::CFG_BIT_WAIT: rx_bitw = data;
      bcr_pkg::CFG_END_TIMEOUT: rx_end = data;
      bcr_pkg::CFG_SAMPLE_READS: rx_reads = data[3:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // result check, register tracking and line sample prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0d data %0h",
                   $time, out_ch.result_kind, out_ch.data_byte);
          error_count++;
        end else begin
          oldest = pending_results.pop_front();
          compare_field("result_kind", oldest.result_kind, out_ch.result_kind);
          compare_field("data_byte", oldest.data_byte, out_ch.data_byte);
          compare_field("byte_index", oldest.byte_index, out_ch.byte_index);
          compare_field("checksum", oldest.checksum, out_ch.checksum);
        end
      end
      if (cfg_we) update_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) track_line_sample(in_ch.line_level);
    end
  end

  // result side stalls
  initial begin
    out_ch.ready = 1'b0;
    mode_left = 0;
    beat = 0;
    drain_mode = DRAIN_FREE;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          drain_mode = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(32, 400);
        end
        mode_left--;
        beat++;
        case (drain_mode)
          DRAIN_FREE: out_ch.ready <= 1'b1;
          DRAIN_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
          DRAIN_SLOW: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (beat % 5 >= 2);
        endcase
      end
    end
  end

  initial begin
    #(64'd200_000 * 12);
    $display("CHECKS FAILED");
    $finish;
  end

  // one line sample transfer; called and returns at a falling edge, valid left high
  task automatic send_sample(input logic lvl);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (gap_max != 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, gap_max) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.line_level <= lvl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    samples_sent++;
    @(negedge clk);
  endtask

  // one character shaped to the current timing, then stop_len idle samples
  task automatic send_char(input logic [7:0] data, input bit bad_parity,
                           input int unsigned stop_len, input int unsigned noise);
    int unsigned first_at[9];
    int unsigned last;
    int j;
    logic [8:0] bits;
    logic lvl;
    first_at[0] = (rx_first != 0) ? rx_first : 1;
    first_at[1] = first_at[0] + span(rx_second);
    for (int k = 2; k < 9; k++) first_at[k] = first_at[k-1] + span(rx_bitw);
    bits = {(^data) ^ bad_parity, data};
    last = first_at[8] + reads_eff() - 1;
    j = -1;
    for (int unsigned t = 0; t <= last + stop_len; t++) begin
      while (j < 8 && first_at[j+1] <= t) j++;
      lvl = (t > last) ? 1'b1 : (j < 0) ? 1'b0 : bits[j];
      if (noise != 0 && $urandom_range(0, noise) == 0) lvl = ~lvl;
      send_sample(lvl);
    end
  endtask

  // enough idle samples to finish any character and end the telegram
  task automatic flush_line();
    int unsigned n;
    n = ((rx_first != 0) ? rx_first : 1) + span(rx_second) + 7 * span(rx_bitw)
        + reads_eff() + rx_end + 2;
    repeat (n) send_sample(1'b1);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config(input logic [15:0] fw, sw, bw, et, input logic [3:0] rd);
    bcr_pkg::cfg_idx_t idxs[6];
    logic [15:0] vals[6];
    idxs = '{bcr_pkg::CFG_FIRST_WAIT, bcr_pkg::CFG_SECOND_WAIT, bcr_pkg::CFG_BIT_WAIT,
             bcr_pkg::CFG_END_TIMEOUT, bcr_pkg::CFG_SAMPLE_READS, CFG_NO_REG};
    vals = '{fw, sw, bw, et, {12'd0, rd}, 16'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // idle line right after reset, default timing
  task automatic test_reset_timing();
    repeat (16) send_sample(1'b1);
    settle();
  endtask

  task automatic test_field_extremes();
    load_config(16'd3, 16'd2, 16'd2, 16'd6, 4'd2);
    send_char(8'h00, 1'b0, 2, 0);
    send_char(8'hFF, 1'b0, 1, 0);
    send_char(8'h55, 1'b0, 3, 0);
    send_char(8'h80, 1'b1, 2, 0);
    send_char(8'h01, 1'b0, 2, 0);
    flush_line();
    // parity error only, so the telegram end carries a zero count
    send_char(8'h7E, 1'b1, 2, 0);
    flush_line();
    // short glitch on an idle line
    send_sample(1'b0);
    flush_line();
    settle();
  endtask

  task automatic test_wait_corners();
    load_config(16'd0, 16'd0, 16'd0, 16'd2, 4'd0);
    send_char(8'hA7, 1'b0, 1, 0);
    send_char(8'h5A, 1'b1, 1, 0);
    send_char(8'h19, 1'b0, 1, 0);
    flush_line();
    settle();
    load_config(16'd1, 16'd1, 16'd1, 16'd6, 4'd15);
    send_char(8'hE4, 1'b0, 2, 0);
    flush_line();
    settle();
    load_config(16'd2, 16'd3, 16'd1, 16'd5, 4'd3);
    send_char(8'h96, 1'b0, 3, 0);
    send_char(8'h6D, 1'b1, 2, 0);
    flush_line();
    settle();
  endtask

  task automatic test_position_saturation();
    logic [7:0] d;
    load_config(16'd1, 16'd1, 16'd1, 16'd3, 4'd1);
    // odd data keeps the parity sample high, so the next start bit is an edge
    repeat (66) begin
      d = 8'($urandom);
      if (^d == 1'b0) d[0] = ~d[0];
      send_char(d, 1'b0, 0, 0);
    end
    flush_line();
    settle();
  endtask

  task automatic test_result_hold();
    load_config(16'd1, 16'd1, 16'd1, 16'd5, 4'd2);
    hold_req = 1'b1;
    repeat (6) send_char(8'($urandom), 1'($urandom_range(0, 5) == 0), $urandom_range(1, 3), 0);
    flush_line();
    settle();
  endtask

  task automatic test_long_waits();
    gap_max = 0;
    load_config(16'd40, 16'd1, 16'd2, 16'd20, 4'd4);
    send_char(8'hD2, 1'b0, rx_end, 0);
    settle();
    gap_max = 6;
  endtask

  task automatic test_random_traffic();
    int unsigned sample_mark;
    int unsigned result_mark;
    int unsigned chars;
    int unsigned stop;
    sample_mark = samples_sent;
    result_mark = results_seen;
    while (samples_sent - sample_mark < RANDOM_SAMPLES ||
           results_seen - result_mark < RANDOM_RESULTS) begin
      load_config(16'(($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                  : $urandom_range(0, 6)),
                  16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  16'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(3, 12)),
                  4'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 4)));
      repeat ($urandom_range(1, 2)) begin
        chars = $urandom_range(1, 4);
        for (int c = 0; c < chars; c++) begin
          if ($urandom_range(0, 11) == 0) stop = 0;
          else if (c == chars - 1) stop = rx_end + $urandom_range(0, 2);
          else stop = $urandom_range(1, (rx_end > 1) ? rx_end - 1 : 1);
          send_char(8'($urandom), 1'($urandom_range(0, 7) == 0), stop,
                    ($urandom_range(0, 9) == 0) ? 6 : 0);
        end
      end
      flush_line();
      settle();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.line_level = 1'b1;
    cfg_we = 1'b0;
    cfg_index = bcr_pkg::CFG_FIRST_WAIT;
    cfg_wdata = '0;
    hold_req = 1'b0;
    error_count = 0;
    results_seen = 0;
    samples_sent = 0;
    burst_left = 0;
    gap_max = 6;
    rx_first = bcr_pkg::FIRST_WAIT_RST;
    rx_second = bcr_pkg::SECOND_WAIT_RST;
    rx_bitw = bcr_pkg::BIT_WAIT_RST;
    rx_end = bcr_pkg::END_TIMEOUT_RST;
    rx_reads = bcr_pkg::SAMPLE_READS_RST;
    ph = bcr_pkg::PH_IDLE;
    tick_cnt = 0;
    bit_no = 0;
    reads_left = 0;
    bit_and = 1'b1;
    shift_reg = 8'h00;
    parity_sum = 1'b0;
    byte_pos = 6'd0;
    xor_sum = 8'h00;
    prev_level = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_timing();
    test_field_extremes();
    test_wait_corners();
    test_position_saturation();
    test_result_hold();
    test_long_waits();
    test_random_traffic();

    settle();
    repeat (10) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
